### hw/rtl/pitrb_pkg.sv
// Shared types and constants for the rotated box point tester.
package pitrb_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 23;
    localparam int TRIG_W  = 16;
    localparam int SLOT_W  = 5;
    localparam int MASK_W  = 32;
    localparam int SLOT_LIMIT = 32;

    // Stream payload widths (padded to whole bytes)
    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_BOXES_IN_USE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_XY_MARGIN    = 1'b1;
    localparam logic [7:0] MARGIN_RESET = 8'd3;

    // Item kinds carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Heading trig clamp bounds, Q1.14
    localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] TRIG_MIN = -16'sd16384;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // One stored box slot
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [SIZE_W-1:0]         len_x;
        logic [SIZE_W-1:0]         len_y;
        logic [SIZE_W-1:0]         len_z;
        logic signed [TRIG_W-1:0]  cosine;
        logic signed [TRIG_W-1:0]  sine;
    } box_t;

    function automatic logic signed [TRIG_W-1:0] clamp_trig(
        input logic signed [TRIG_W-1:0] v
    );
        logic signed [TRIG_W-1:0] r;
        r = v;
        if (v > TRIG_MAX)
            r = TRIG_MAX;
        else if (v < TRIG_MIN)
            r = TRIG_MIN;
        return r;
    endfunction

endpackage

### hw/rtl/pitrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pitrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/point_in_rotated_box_test.sv
// Top level: tests a point against a table of yaw-rotated 3D boxes.
//
// Usage:
//   Input stream s_*: tuser selects the kind of item (0 load box, 1 test
//   point). A load item writes the box in tdata into slot box_slot and
//   gives no result; it leaves s_tready high. A test item gives one result
//   on m_*: a mask with one bit per tested slot plus an any-hit flag.
//   Slots 0 .. N-1 are tested, N = min(boxes_in_use, MAX_BOXES, 32).
//   One rotate-and-compare pipeline handles one stored box per cycle, fed
//   by one read port of the box RAM; its stages are the RAM read, offsets,
//   products and local frame coordinates, then the mask accumulate. A test
//   item holds s_tready low while its N reads issue, the pipeline drains
//   and the output register is loaded, which raises m_tvalid (no reads at N = 0).
//   The result sits in an output register: the next item is accepted while
//   it waits. A further test result waits until the receiver takes the
//   previous one; s_tready stays low meanwhile.
//   Config (cfg_we/cfg_index/cfg_wdata) must be written only while idle; the block does not enforce this.
//   Reset clears control state and registers (boxes_in_use 0, xy_margin 3);
//   box slots hold garbage until loaded.
module point_in_rotated_box_test #(
    parameter int MAX_BOXES = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata from bit 0: box_slot, pos_x, pos_y, pos_z, size_x, size_y,
    // size_z, heading_cos, heading_sin, zero pad
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pitrb_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                   s_tuser,   // opcode
    // m_tdata from bit 0: in_box_mask, any_hit, zero pad
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pitrb_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                   cfg_we,
    input  logic [pitrb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pitrb_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int DEPTH  = (MAX_BOXES < pitrb_pkg::SLOT_LIMIT) ?
                            MAX_BOXES : pitrb_pkg::SLOT_LIMIT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BOX_W  = $bits(pitrb_pkg::box_t);

    // ---------------- input unpacking ----------------
    logic [4:0]          in_slot;
    logic signed [23:0]  in_pos_x, in_pos_y, in_pos_z;
    logic [22:0]         in_size_x, in_size_y, in_size_z;
    logic signed [15:0]  in_cos, in_sin;

    assign in_slot   = s_tdata[4:0];
    assign in_pos_x  = s_tdata[28:5];
    assign in_pos_y  = s_tdata[52:29];
    assign in_pos_z  = s_tdata[76:53];
    assign in_size_x = s_tdata[99:77];
    assign in_size_y = s_tdata[122:100];
    assign in_size_z = s_tdata[145:123];
    assign in_cos    = s_tdata[161:146];
    assign in_sin    = s_tdata[177:162];

    // ---------------- control ----------------
    pitrb_pkg::state_t state_reg, state_next;
    logic [5:0]        boxes_in_use_reg;
    logic [7:0]        xy_margin_reg;
    logic [5:0]        limit_reg;
    logic [5:0]        cnt_reg;
    logic [5:0]        limit_now;
    logic              in_accept, test_accept, load_accept;
    logic              issue, load_out, pipe_busy;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [pitrb_pkg::MASK_W-1:0] mask_reg;
    logic [pitrb_pkg::MASK_W-1:0] out_mask_reg;
    logic              out_hit_reg;
    logic              m_tvalid_reg;

    assign s_tready    = (state_reg == pitrb_pkg::ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign test_accept = in_accept && (s_tuser == pitrb_pkg::OP_TEST);
    assign load_accept = in_accept && (s_tuser == pitrb_pkg::OP_LOAD);
    assign pipe_busy   = v1_reg || v2_reg || v3_reg || v4_reg;
    assign limit_now   = (boxes_in_use_reg > 6'(DEPTH)) ? 6'(DEPTH) : boxes_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pitrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            pitrb_pkg::ST_IDLE:
            begin
                if (test_accept)
                begin
                    state_next = (limit_now == 6'd0) ? pitrb_pkg::ST_FINISH
                                                     : pitrb_pkg::ST_RUN;
                end
            end
            pitrb_pkg::ST_RUN:
            begin
                issue = 1'b1;
                if (cnt_reg == limit_reg - 6'd1)
                begin
                    state_next = pitrb_pkg::ST_DRAIN;
                end
            end
            pitrb_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = pitrb_pkg::ST_FINISH;
                end
            end
            pitrb_pkg::ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = pitrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pitrb_pkg::ST_IDLE;
            end
        endcase
    end

    // Config registers, sequencer counters and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boxes_in_use_reg <= '0;
            xy_margin_reg    <= pitrb_pkg::MARGIN_RESET;
            limit_reg        <= '0;
            cnt_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == pitrb_pkg::REG_BOXES_IN_USE))
            begin
                boxes_in_use_reg <= cfg_wdata[5:0];
            end
            if (cfg_we && (cfg_index == pitrb_pkg::REG_XY_MARGIN))
            begin
                xy_margin_reg <= cfg_wdata;
            end
            if (test_accept)
            begin
                limit_reg <= limit_now;
                cnt_reg   <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- box storage ----------------
    pitrb_pkg::box_t wr_box, rd_box;
    logic [BOX_W-1:0] rd_word;
    logic             ram_we;

    always_comb
    begin
        wr_box.center_x = in_pos_x;
        wr_box.center_y = in_pos_y;
        wr_box.center_z = in_pos_z;
        wr_box.len_x    = in_size_x;
        wr_box.len_y    = in_size_y;
        wr_box.len_z    = in_size_z;
        wr_box.cosine   = pitrb_pkg::clamp_trig(in_cos);
        wr_box.sine     = pitrb_pkg::clamp_trig(in_sin);
    end

    // Loads to slots beyond the table are dropped
    assign ram_we = load_accept && ({1'b0, in_slot} < 6'(DEPTH));

    pitrb_ram #(
        .WIDTH (BOX_W),
        .DEPTH (DEPTH)
    ) u_box_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_slot[ADDR_W-1:0]),
        .wdata (wr_box),
        .re    (issue),
        .raddr (cnt_reg[ADDR_W-1:0]),
        .rdata (rd_word)
    );

    assign rd_box = pitrb_pkg::box_t'(rd_word);

    // ---------------- rotate-and-compare pipeline ----------------
    logic signed [23:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [ADDR_W-1:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    // stage 2: offsets
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic [22:0]        len_x2_reg, len_y2_reg, len_z2_reg;
    logic signed [15:0] cos2_reg, sin2_reg;

    // stage 3: products, z test, xy bounds
    logic signed [40:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic               z_ok3_reg;
    logic [23:0]        bx3_reg, by3_reg;
    logic signed [25:0] two_dz, len_z_s;
    logic               z_ok;

    // stage 4: local frame coordinates
    logic signed [41:0] lx_reg, ly_reg;
    logic               z_ok4_reg;
    logic [23:0]        bx4_reg, by4_reg;

    logic signed [43:0] two_lx, two_ly, bound_x, bound_y;
    logic               x_ok, y_ok, hit;

    assign two_dz  = {dz_reg, 1'b0};
    assign len_z_s = {3'b000, len_z2_reg};
    assign z_ok    = dz_reg[24] ? (two_dz >= -len_z_s) : (two_dz <= len_z_s);

    // 2|L| < B is checked without taking the magnitude
    assign two_lx  = {lx_reg[41], lx_reg, 1'b0};
    assign two_ly  = {ly_reg[41], ly_reg, 1'b0};
    assign bound_x = {6'b0, bx4_reg, 14'b0};
    assign bound_y = {6'b0, by4_reg, 14'b0};
    assign x_ok    = lx_reg[41] ? (two_lx > -bound_x) : (two_lx < bound_x);
    assign y_ok    = ly_reg[41] ? (two_ly > -bound_y) : (two_ly < bound_y);
    assign hit     = z_ok4_reg && x_ok && y_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (test_accept)
        begin
            pt_x_reg <= in_pos_x;
            pt_y_reg <= in_pos_y;
            pt_z_reg <= in_pos_z;
        end
        idx1_reg <= cnt_reg[ADDR_W-1:0];

        dx_reg     <= 25'(pt_x_reg) - 25'(rd_box.center_x);
        dy_reg     <= 25'(pt_y_reg) - 25'(rd_box.center_y);
        dz_reg     <= 25'(pt_z_reg) - 25'(rd_box.center_z);
        len_x2_reg <= rd_box.len_x;
        len_y2_reg <= rd_box.len_y;
        len_z2_reg <= rd_box.len_z;
        cos2_reg   <= rd_box.cosine;
        sin2_reg   <= rd_box.sine;
        idx2_reg   <= idx1_reg;

        pxc_reg   <= dx_reg * cos2_reg;
        pys_reg   <= dy_reg * sin2_reg;
        pyc_reg   <= dy_reg * cos2_reg;
        pxs_reg   <= dx_reg * sin2_reg;
        z_ok3_reg <= z_ok;
        bx3_reg   <= {1'b0, len_x2_reg} + {15'b0, xy_margin_reg, 1'b0};
        by3_reg   <= {1'b0, len_y2_reg} + {15'b0, xy_margin_reg, 1'b0};
        idx3_reg  <= idx2_reg;

        lx_reg    <= 42'(pxc_reg) + 42'(pys_reg);
        ly_reg    <= 42'(pyc_reg) - 42'(pxs_reg);
        z_ok4_reg <= z_ok3_reg;
        bx4_reg   <= bx3_reg;
        by4_reg   <= by3_reg;
        idx4_reg  <= idx3_reg;
    end

    // ---------------- mask accumulate and output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (test_accept)
        begin
            mask_reg <= '0;
        end
        else if (v4_reg && hit)
        begin
            mask_reg <= mask_reg | (32'd1 << idx4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_mask_reg <= mask_reg;
            out_hit_reg  <= (mask_reg != '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_hit_reg, out_mask_reg};

    // ---------------- assertions ----------------
    a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32] == (m_tdata[31:0] != 32'd0)))
        else $error("any_hit disagrees with mask");

    a_mask_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pitrb_pkg::ST_FINISH) |-> ((mask_reg >> limit_reg) == '0))
        else $error("mask bit set beyond tested slots");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pitrb_pkg::ST_IDLE) |-> !ram_we)
        else $error("box RAM written while a test runs");

    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_busy |-> (state_reg == pitrb_pkg::ST_RUN ||
                       state_reg == pitrb_pkg::ST_DRAIN))
        else $error("pipeline active outside a test");

endmodule

### tb/box_hit_checker.sv
// Checker for the rotated box point tester: tracks loaded boxes, predicts masks, compares.
module box_hit_checker #(
    parameter int MAX_BOXES = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [pitrb_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [pitrb_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [pitrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pitrb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                 errors,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // bit offsets of the item fields in s_tdata
    localparam int P_X = pitrb_pkg::SLOT_W;
    localparam int P_Y = P_X + pitrb_pkg::COORD_W;
    localparam int P_Z = P_Y + pitrb_pkg::COORD_W;
    localparam int L_X = P_Z + pitrb_pkg::COORD_W;
    localparam int L_Y = L_X + pitrb_pkg::SIZE_W;
    localparam int L_Z = L_Y + pitrb_pkg::SIZE_W;
    localparam int T_C = L_Z + pitrb_pkg::SIZE_W;
    localparam int T_S = T_C + pitrb_pkg::TRIG_W;

    logic signed [pitrb_pkg::COORD_W-1:0] ctr_x [pitrb_pkg::SLOT_LIMIT];
    logic signed [pitrb_pkg::COORD_W-1:0] ctr_y [pitrb_pkg::SLOT_LIMIT];
    logic signed [pitrb_pkg::COORD_W-1:0] ctr_z [pitrb_pkg::SLOT_LIMIT];
    logic [pitrb_pkg::SIZE_W-1:0]         len_x [pitrb_pkg::SLOT_LIMIT];
    logic [pitrb_pkg::SIZE_W-1:0]         len_y [pitrb_pkg::SLOT_LIMIT];
    logic [pitrb_pkg::SIZE_W-1:0]         len_z [pitrb_pkg::SLOT_LIMIT];
    logic signed [pitrb_pkg::TRIG_W-1:0]  cos_q [pitrb_pkg::SLOT_LIMIT];
    logic signed [pitrb_pkg::TRIG_W-1:0]  sin_q [pitrb_pkg::SLOT_LIMIT];

    logic [5:0]  slots_active;
    logic [7:0]  margin;
    logic [pitrb_pkg::MASK_W:0] expected_hits [$];   // {any_hit, in_box_mask}
    logic [pitrb_pkg::MASK_W:0] want;
    logic [pitrb_pkg::SLOT_W-1:0] slot;
    logic signed [pitrb_pkg::TRIG_W-1:0] hc, hs;
    int fail_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        // keep the log short if everything goes wrong
        if (fail_count < 100)
            $display("%0d ns: %s mismatch: got %h, expected %h", $time, what, got, exp_val);
        fail_count++;
    endtask

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [pitrb_pkg::MASK_W:0] boxes_hit(
        input logic signed [pitrb_pkg::COORD_W-1:0] px,
        input logic signed [pitrb_pkg::COORD_W-1:0] py,
        input logic signed [pitrb_pkg::COORD_W-1:0] pz
    );
        longint dx, dy, dz, lx, ly, bx, by, hz, c, s, m2;
        logic [pitrb_pkg::MASK_W-1:0] mask;
        int lim;
        mask = '0;
        lim = slots_active;
        if (lim > MAX_BOXES)
            lim = MAX_BOXES;
        if (lim > pitrb_pkg::MASK_W)
            lim = pitrb_pkg::MASK_W;
        m2 = margin;
        m2 = 2 * m2;
        for (int i = 0; i < lim; i++)
        begin
            dx = px - ctr_x[i];
            dy = py - ctr_y[i];
            dz = pz - ctr_z[i];
            c = cos_q[i];
            s = sin_q[i];
            // rotate the offset into the box frame, 14 fraction bits as in the Q1.14 trig
            lx = dx * c + dy * s;
            ly = dy * c - dx * s;
            bx = len_x[i];
            bx = (bx + m2) * 16384;
            by = len_y[i];
            by = (by + m2) * 16384;
            hz = len_z[i];
            if (2 * magnitude(dz) <= hz && 2 * magnitude(lx) < bx && 2 * magnitude(ly) < by)
                mask[i] = 1'b1;
        end
        return {|mask, mask};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_active = '0;
            margin = pitrb_pkg::MARGIN_RESET;
            expected_hits.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pitrb_pkg::REG_BOXES_IN_USE)
                    slots_active = cfg_wdata[5:0];
                else if (cfg_index == pitrb_pkg::REG_XY_MARGIN)
                    margin = cfg_wdata;
            end
            // results first, so a result can never match an item taken on the same edge
            if (m_tvalid && m_tready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, '0);
                else
                begin
                    want = expected_hits.pop_front();
                    if (m_tdata[pitrb_pkg::MASK_W-1:0] !== want[pitrb_pkg::MASK_W-1:0])
                        report_mismatch("in_box_mask", m_tdata[pitrb_pkg::MASK_W-1:0],
                                        want[pitrb_pkg::MASK_W-1:0]);
                    if (m_tdata[pitrb_pkg::MASK_W] !== want[pitrb_pkg::MASK_W])
                        report_mismatch("any_hit", m_tdata[pitrb_pkg::MASK_W],
                                        want[pitrb_pkg::MASK_W]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == pitrb_pkg::OP_LOAD)
                begin
                    slot = s_tdata[pitrb_pkg::SLOT_W-1:0];
                    if (slot < MAX_BOXES)
                    begin
                        hc = $signed(s_tdata[T_C +: pitrb_pkg::TRIG_W]);
                        hs = $signed(s_tdata[T_S +: pitrb_pkg::TRIG_W]);
                        if (hc > pitrb_pkg::TRIG_MAX)
                            hc = pitrb_pkg::TRIG_MAX;
                        else if (hc < pitrb_pkg::TRIG_MIN)
                            hc = pitrb_pkg::TRIG_MIN;
                        if (hs > pitrb_pkg::TRIG_MAX)
                            hs = pitrb_pkg::TRIG_MAX;
                        else if (hs < pitrb_pkg::TRIG_MIN)
                            hs = pitrb_pkg::TRIG_MIN;
                        ctr_x[slot] = s_tdata[P_X +: pitrb_pkg::COORD_W];
                        ctr_y[slot] = s_tdata[P_Y +: pitrb_pkg::COORD_W];
                        ctr_z[slot] = s_tdata[P_Z +: pitrb_pkg::COORD_W];
                        len_x[slot] = s_tdata[L_X +: pitrb_pkg::SIZE_W];
                        len_y[slot] = s_tdata[L_Y +: pitrb_pkg::SIZE_W];
                        len_z[slot] = s_tdata[L_Z +: pitrb_pkg::SIZE_W];
                        cos_q[slot] = hc;
                        sin_q[slot] = hs;
                    end
                end
                else
                    expected_hits.push_back(
                        boxes_hit($signed(s_tdata[P_X +: pitrb_pkg::COORD_W]),
                                  $signed(s_tdata[P_Y +: pitrb_pkg::COORD_W]),
                                  $signed(s_tdata[P_Z +: pitrb_pkg::COORD_W])));
            end
        end
        errors <= fail_count;
        pending <= expected_hits.size();
    end

endmodule

### tb/point_in_rotated_box_test_test.sv
// Testbench top: drives loads and point tests into the box tester and gives the verdict.
module point_in_rotated_box_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BOXES    = 32;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 158;
    localparam int HOLD_PHASE   = 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_BOXES + 16;
    localparam int PAD_W = pitrb_pkg::IN_DATA_W - (pitrb_pkg::SLOT_W + 3 * pitrb_pkg::COORD_W
                           + 3 * pitrb_pkg::SIZE_W + 2 * pitrb_pkg::TRIG_W);

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [pitrb_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [pitrb_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                              cfg_we;
    logic [pitrb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pitrb_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    int mismatches;
    int outstanding;
    int phase_no;

    // what the stimulus last loaded per slot, used to aim points at boxes
    int aim_x [MAX_BOXES];
    int aim_y [MAX_BOXES];
    int aim_z [MAX_BOXES];
    int aim_sx [MAX_BOXES];
    int aim_sy [MAX_BOXES];
    int aim_sz [MAX_BOXES];

    point_in_rotated_box_test #(
        .MAX_BOXES(MAX_BOXES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    box_hit_checker #(
        .MAX_BOXES(MAX_BOXES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .errors(mismatches),
        .pending(outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [pitrb_pkg::IN_DATA_W-1:0] pack_item(input int slot, input int px,
                                                                  input int py, input int pz,
                                                                  input int sx, input int sy,
                                                                  input int sz, input int hc,
                                                                  input int hs);
        return {{PAD_W{1'b0}}, hs[pitrb_pkg::TRIG_W-1:0], hc[pitrb_pkg::TRIG_W-1:0],
                sz[pitrb_pkg::SIZE_W-1:0], sy[pitrb_pkg::SIZE_W-1:0],
                sx[pitrb_pkg::SIZE_W-1:0], pz[pitrb_pkg::COORD_W-1:0],
                py[pitrb_pkg::COORD_W-1:0], px[pitrb_pkg::COORD_W-1:0],
                slot[pitrb_pkg::SLOT_W-1:0]};
    endfunction

    task automatic send_item(input logic op, input logic [pitrb_pkg::IN_DATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic probe(input int px, input int py, input int pz);
        send_item(pitrb_pkg::OP_TEST, pack_item(0, px, py, pz, 0, 0, 0, 0, 0));
    endtask

    // wait for every result, then let any item still in flight finish
    task automatic settle();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] boxes, input logic [7:0] mg);
        cfg_we <= 1'b1;
        cfg_index <= pitrb_pkg::REG_BOXES_IN_USE;
        cfg_wdata <= boxes;
        @(posedge clk);
        cfg_index <= pitrb_pkg::REG_XY_MARGIN;
        cfg_wdata <= mg;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_box(input int slot);
        int kind, cx, cy, cz, sx, sy, sz, hc, hs;
        real ang;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            // anything the fields allow, trig included
            cx = int'($urandom) >>> 8;
            cy = int'($urandom) >>> 8;
            cz = int'($urandom) >>> 8;
            sx = $urandom_range(0, 8388607);
            sy = $urandom_range(0, 8388607);
            sz = $urandom_range(0, 8388607);
            hc = int'($urandom) >>> 16;
            hs = int'($urandom) >>> 16;
        end
        else
        begin
            // boxes clustered so that they overlap
            cx = int'($urandom_range(0, 4096)) - 2048;
            cy = int'($urandom_range(0, 4096)) - 2048;
            cz = int'($urandom_range(0, 512)) - 256;
            sx = $urandom_range(128, 3000);
            sy = $urandom_range(128, 2000);
            sz = $urandom_range(64, 1024);
            if (kind < 7)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        hc = 16384;
                        hs = 0;
                    end
                    1:
                    begin
                        hc = 0;
                        hs = 16384;
                    end
                    2:
                    begin
                        hc = -16384;
                        hs = 0;
                    end
                    default:
                    begin
                        hc = 0;
                        hs = -16384;
                    end
                endcase
            end
            else
            begin
                ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
                hc = int'(16384.0 * $cos(ang));
                hs = int'(16384.0 * $sin(ang));
            end
        end
        aim_x[slot] = cx;
        aim_y[slot] = cy;
        aim_z[slot] = cz;
        aim_sx[slot] = sx;
        aim_sy[slot] = sy;
        aim_sz[slot] = sz;
        send_item(pitrb_pkg::OP_LOAD, pack_item(slot, cx, cy, cz, sx, sy, sz, hc, hs));
    endtask

    initial
    begin : receiver
        int mode, left, k;
        bit held;
        mode = 0;
        left = 0;
        k = 0;
        held = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && phase_no == HOLD_PHASE)
            begin
                // long hold-off: the output register fills and the input stalls
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(64, 256);
            end
            left--;
            k++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ((k % 8) < 3);
            endcase
        end
    end

    initial
    begin : stimulus
        int ph, k, burst, gap, t, r, px, py, pz;
        logic [7:0] n, mg;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = pitrb_pkg::OP_LOAD;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = pitrb_pkg::REG_BOXES_IN_USE;
        cfg_wdata = '0;
        phase_no = -1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no slots in use after reset: empty mask
        probe(0, 0, 0);
        send_item(pitrb_pkg::OP_LOAD, pack_item(0, 0, 0, 0, 512, 512, 512, 16384, 0));
        // trig beyond range gets clamped
        send_item(pitrb_pkg::OP_LOAD, pack_item(1, 4000, -4000, 100, 2000, 600, 8388607,
                                                32767, -32768));
        send_item(pitrb_pkg::OP_LOAD, pack_item(2, -8388608, 8388607, -8388608, 8388607,
                                                8388607, 8388607, 11585, 11585));
        s_tvalid <= 1'b0;
        settle();
        set_config(8'd3, 8'd0);
        // x and y faces are open, z faces closed
        probe(255, 0, 0);
        probe(256, 0, 0);
        probe(-255, 0, 0);
        probe(-256, 0, 0);
        probe(0, 255, 0);
        probe(0, -256, 0);
        probe(0, 0, 256);
        probe(0, 0, 257);
        probe(0, 0, -256);
        probe(4000, -4000, 100);
        probe(8388607, -8388608, 8388607);
        probe(-8388608, 8388607, -8388608);
        probe(-8388000, 8388000, -8388000);
        s_tvalid <= 1'b0;
        settle();
        set_config(8'd3, 8'd255);
        probe(500, 0, 0);
        probe(510, -510, 0);
        probe(511, 0, 0);

        for (t = 0; t < MAX_BOXES; t++)
            load_box(t);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            s_tvalid <= 1'b0;
            settle();
            case (ph)
                0:
                begin
                    n = 8'd32;
                    mg = 8'd3;
                end
                1:
                begin
                    n = 8'd63;
                    mg = 8'd0;
                end
                2:
                begin
                    n = 8'd1;
                    mg = 8'd255;
                end
                3:
                begin
                    n = 8'd32;
                    mg = $urandom_range(0, 255);
                end
                4:
                begin
                    n = 8'd0;
                    mg = 8'd17;
                end
                5:
                begin
                    n = 8'hE1;
                    mg = 8'd255;
                end
                6:
                begin
                    n = $urandom_range(2, 31);
                    mg = $urandom_range(0, 255);
                end
                7:
                begin
                    n = 8'd31;
                    mg = 8'd0;
                end
                8:
                begin
                    n = 8'd16;
                    mg = 8'd128;
                end
                9:
                begin
                    n = 8'd32;
                    mg = 8'd255;
                end
                10:
                begin
                    n = $urandom_range(1, 32);
                    mg = $urandom_range(0, 255);
                end
                default:
                begin
                    n = 8'd40;
                    mg = 8'd3;
                end
            endcase
            set_config(n, mg);
            phase_no <= ph;
            k = 0;
            while (k < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && k < PHASE_ITEMS)
                begin
                    if ($urandom_range(0, 3) == 0)
                        load_box($urandom_range(0, MAX_BOXES - 1));
                    else
                    begin
                        t = $urandom_range(0, MAX_BOXES - 1);
                        r = $urandom_range(0, 19);
                        if (r < 12)
                        begin
                            px = aim_x[t] + int'($urandom_range(0, aim_sx[t] + 64))
                                 - (aim_sx[t] + 64) / 2;
                            py = aim_y[t] + int'($urandom_range(0, aim_sy[t] + 64))
                                 - (aim_sy[t] + 64) / 2;
                            pz = aim_z[t] + int'($urandom_range(0, aim_sz[t] + 16))
                                 - (aim_sz[t] + 16) / 2;
                            // on the top face, and just above it
                            if (r < 2)
                                pz = aim_z[t] + aim_sz[t] / 2 + r;
                        end
                        else if (r < 17)
                        begin
                            px = int'($urandom_range(0, 6000)) - 3000;
                            py = int'($urandom_range(0, 6000)) - 3000;
                            pz = int'($urandom_range(0, 1200)) - 600;
                        end
                        else
                        begin
                            px = int'($urandom) >>> 8;
                            py = int'($urandom) >>> 8;
                            pz = int'($urandom) >>> 8;
                        end
                        send_item(pitrb_pkg::OP_TEST,
                                  pack_item($urandom, px, py, pz, $urandom, $urandom,
                                            $urandom, $urandom, $urandom));
                    end
                    k++;
                    burst--;
                    if (k == PHASE_ITEMS / 2 && (ph % 4) == 2)
                    begin
                        // sender waits until the block has delivered everything
                        s_tvalid <= 1'b0;
                        settle();
                    end
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if ((ph % 3) == 1)
                    gap = 0;
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        s_tvalid <= 1'b0;
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
